@@ src/percent_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Percent decoder assertion macros
// Shared property forms used by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef PERCENT_DECODER_ASSERT_SVH
`define PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define PDEC_ASSERT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("percent decoder assertion failed");

// Next-cycle implication, checked while out of reset.
`define PDEC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("percent decoder assertion failed");

`endif

@@ src/pdec_pkg.sv @@
// ----------------------------------------------------------------------------
// Percent decoder package
// Types, character constants and hex helpers shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pdec_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned Q_PTR_W    = 1;
  localparam int unsigned Q_DEPTH    = 1 << Q_PTR_W;

  localparam logic [CFG_IDX_W-1:0] REG_STRICT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW3 = 3'd4;

  localparam logic [CFG_DATA_W-1:0] ALLOW0_RST = 64'h03FF_6000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ALLOW1_RST = 64'h47FF_FFFE_87FF_FFFE;
  localparam logic [CFG_DATA_W-1:0] ALLOW2_RST = 64'h0;
  localparam logic [CFG_DATA_W-1:0] ALLOW3_RST = 64'h0;

  localparam logic [7:0] CHAR_PCT = 8'h25;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_LF  = 8'h66;
  localparam logic [7:0] CHAR_UA  = 8'h41;
  localparam logic [7:0] CHAR_UF  = 8'h46;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_phase_e;

  // One queue entry: the one to three results caused by a single item.
  // Only the final result may carry last or error.
  typedef struct packed {
    logic [1:0]              cnt;
    logic [MAX_RES-1:0][7:0] data;
    logic                    last;
    logic                    err;
  } pdec_cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_LA && c <= CHAR_LF) ||
           (c >= CHAR_UA && c <= CHAR_UF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      v = c - CHAR_0;
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      v = c - CHAR_UA + HEX_TEN;
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      v = c - CHAR_LA + HEX_TEN;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

@@ src/pdec_front.sv @@
// ----------------------------------------------------------------------------
// Percent decoder front end
// Holds the configuration, tracks escape state and turns each item that
// gives results into one queue entry describing them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "percent_decoder_assert.svh"

module pdec_front import pdec_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  in_last_i,
  output logic                       cmd_valid_o,
  input  wire logic                  cmd_ready_i,
  output pdec_cmd_t                  cmd_o
);

  logic                  strict_q;
  logic [CFG_DATA_W-1:0] allow0_q, allow1_q, allow2_q, allow3_q;
  esc_phase_e            phase_q, phase_d;
  logic [7:0]            held_q, held_d;
  logic                  disc_q, disc_d;

  logic [4*CFG_DATA_W-1:0] allow_vec;
  logic                    allowed;
  logic                    b_hex;
  logic                    b_pct;
  logic [7:0]              decoded;
  logic                    in_fire;
  logic                    fail;
  logic                    replay;
  logic [1:0]              n;
  pdec_cmd_t               cmd;

  assign allow_vec = {allow3_q, allow2_q, allow1_q, allow0_q};
  assign allowed   = allow_vec[in_byte_i];
  assign b_hex     = is_hex(in_byte_i);
  assign b_pct     = (in_byte_i == CHAR_PCT);
  assign decoded   = {hex_val(held_q), hex_val(in_byte_i)};

  assign in_ready_o  = cmd_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cmd_valid_o = in_valid_i && (cmd.cnt != 2'd0);
  assign cmd_o       = cmd;

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    disc_d  = disc_q;
    cmd     = '0;
    n       = 2'd0;
    fail    = 1'b0;
    replay  = 1'b0;
    if (disc_q) begin
      phase_d = ESC_IDLE;
      if (in_last_i) begin
        disc_d = 1'b0;
      end
    end else if (strict_q) begin
      unique case (phase_q)
        ESC_PCT: begin
          if (b_hex && !in_last_i) begin
            held_d  = in_byte_i;
            phase_d = ESC_DIGIT;
          end else begin
            fail = 1'b1;
          end
        end
        ESC_DIGIT: begin
          if (b_hex) begin
            cmd.data[0] = decoded;
            n           = 2'd1;
            phase_d     = ESC_IDLE;
          end else begin
            fail = 1'b1;
          end
        end
        default: begin
          if (b_pct) begin
            if (in_last_i) begin
              fail = 1'b1;
            end else begin
              phase_d = ESC_PCT;
            end
          end else if (allowed) begin
            cmd.data[0] = in_byte_i;
            n           = 2'd1;
            phase_d     = ESC_IDLE;
          end else begin
            fail = 1'b1;
          end
        end
      endcase
      if (fail) begin
        cmd.data[0] = 8'd0;
        n           = 2'd1;
        phase_d     = ESC_IDLE;
        disc_d      = !in_last_i;
      end
    end else begin
      unique case (phase_q)
        ESC_PCT: begin
          if (b_hex) begin
            if (in_last_i) begin
              cmd.data[0] = CHAR_PCT;
              cmd.data[1] = in_byte_i;
              n           = 2'd2;
              phase_d     = ESC_IDLE;
            end else begin
              held_d  = in_byte_i;
              phase_d = ESC_DIGIT;
            end
          end else begin
            cmd.data[0] = CHAR_PCT;
            n           = 2'd1;
            replay      = 1'b1;
          end
        end
        ESC_DIGIT: begin
          if (b_hex) begin
            cmd.data[0] = decoded;
            n           = 2'd1;
            phase_d     = ESC_IDLE;
          end else begin
            cmd.data[0] = CHAR_PCT;
            cmd.data[1] = held_q;
            n           = 2'd2;
            replay      = 1'b1;
          end
        end
        default: begin
          replay = 1'b1;
        end
      endcase
      // The current byte is handled afresh as if no escape were pending.
      if (replay) begin
        if (b_pct && !in_last_i) begin
          phase_d = ESC_PCT;
        end else begin
          cmd.data[n] = in_byte_i;
          n           = n + 2'd1;
          phase_d     = ESC_IDLE;
        end
      end
    end
    cmd.cnt  = n;
    cmd.last = fail || in_last_i;
    cmd.err  = fail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b0;
      allow0_q <= ALLOW0_RST;
      allow1_q <= ALLOW1_RST;
      allow2_q <= ALLOW2_RST;
      allow3_q <= ALLOW3_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STRICT: strict_q <= cfg_data_i[0];
        REG_ALLOW0: allow0_q <= cfg_data_i;
        REG_ALLOW1: allow1_q <= cfg_data_i;
        REG_ALLOW2: allow2_q <= cfg_data_i;
        REG_ALLOW3: allow3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ESC_IDLE;
      held_q  <= 8'd0;
      disc_q  <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      disc_q  <= disc_d;
    end
  end

  `PDEC_ASSERT(a_disc_no_escape, disc_q, phase_q == ESC_IDLE)

endmodule

`default_nettype wire

@@ src/pdec_fifo.sv @@
// ----------------------------------------------------------------------------
// Percent decoder command queue
// Two-entry queue that decouples the front end from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "percent_decoder_assert.svh"

module pdec_fifo import pdec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  input  wire pdec_cmd_t  push_data_i,
  output logic            pop_valid_o,
  input  wire logic       pop_i,
  output pdec_cmd_t       pop_data_o
);

  pdec_cmd_t            mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]     count_q, count_d;
  logic                 push;
  logic                 pop;

  assign push_ready_o = (count_q != Q_DEPTH[Q_PTR_W:0]);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `PDEC_ASSERT(a_count_bound, 1'b1, count_q <= Q_DEPTH[Q_PTR_W:0])
  `PDEC_ASSERT_NXT(a_push_fills, push && !pop, count_q != '0)
  `PDEC_ASSERT(a_entry_nonempty, pop_valid_o, pop_data_o.cnt != 2'd0)

endmodule

`default_nettype wire

@@ src/pdec_back.sv @@
// ----------------------------------------------------------------------------
// Percent decoder output stage
// Expands each queue entry into its results, one result per cycle while the
// receiver is ready, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "percent_decoder_assert.svh"

module pdec_back import pdec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  wire pdec_cmd_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            decode_error_o
);

  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       err_q;
  logic [1:0] sub_q;
  logic       load;
  logic       final_sel;

  assign load      = head_valid_i && (!out_valid_q || out_ready_i);
  assign final_sel = (sub_q == head_i.cnt - 2'd1);
  assign pop_o     = load && final_sel;

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign out_last_o     = last_q;
  assign decode_error_o = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 2'd0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      sub_q       <= final_sel ? 2'd0 : sub_q + 2'd1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.data[sub_q];
      last_q <= final_sel && head_i.last;
      err_q  <= final_sel && head_i.err;
    end
  end

  `PDEC_ASSERT(a_err_is_last, out_valid_q && err_q, last_q && (byte_q == 8'd0))
  `PDEC_ASSERT(a_sub_in_range, head_valid_i, sub_q < head_i.cnt)

endmodule

`default_nettype wire

@@ src/percent_decoder.sv @@
// ----------------------------------------------------------------------------
// Percent decoder
// Streaming URL percent decoder, one encoded byte per input item.
// ----------------------------------------------------------------------------
// Input items carry one raw byte and a flag for the last byte of a string;
// output items carry a decoded byte, a last flag and an error flag. Both
// channels use valid and ready. Registers are written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must do so only while the block is
// idle, which the block itself does not enforce. Items with no result or
// one result let plain text and escapes stream at one byte per cycle while
// the receiver keeps up. A broken escape in permissive mode gives one to
// three results; the output stage sends one result per cycle while the
// receiver is ready, which sets the rate for such items.
// A two-entry queue sits between the front end and the output register, so
// input is taken while a result waits. When the receiver stalls, the output
// register holds, the queue fills and in_ready_o drops after two entries.
// Reset empties the queue and output, clears the escape state and restores
// the register defaults; there is no start-up sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module percent_decoder import pdec_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  in_last_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_last_o,
  output logic                       decode_error_o
);

  logic      cmd_valid;
  logic      cmd_ready;
  pdec_cmd_t cmd;
  logic      head_valid;
  pdec_cmd_t head;
  logic      pop;

  pdec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  pdec_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (head_valid),
    .pop_i        (pop),
    .pop_data_o   (head)
  );

  pdec_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .decode_error_o (decode_error_o)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Percent decoder testbench
// Streams encoded strings through the decoder in permissive and strict mode
// and compares every decoded item with a predictor kept in the testbench.
// Directed strings cover the escape corners, then random strings run with
// random gaps on both channels; a final string meets one long output stall.
// ----------------------------------------------------------------------------

module testbench;
  import pdec_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } dec_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            in_byte_i = '0;
  logic                  in_last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [7:0]            out_byte_o;
  logic                  out_last_o;
  logic                  decode_error_o;

  logic            mode_strict;
  logic [63:0]     allow_mask [4];
  esc_phase_e      esc_state;
  logic [7:0]      first_digit;
  logic            dropping;
  dec_result_t     expected_q [$];
  logic [7:0]      pending_str [$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int valid_gap_pct  = 0;
  int ready_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int bytes_sent     = 0;

  percent_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .decode_error_o (decode_error_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  function automatic logic hex_digit(input logic [7:0] c);
    return c inside {[CHAR_0:CHAR_9], [CHAR_LA:CHAR_LF], [CHAR_UA:CHAR_UF]};
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    if (c <= CHAR_9) begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  function automatic void push_result(input logic [7:0] d, input logic l, input logic e);
    dec_result_t r;
    r.data = d;
    r.last = l;
    r.err  = e;
    expected_q.push_back(r);
  endfunction

  function automatic void decode_plain(input logic [7:0] b, input logic l);
    if (b == CHAR_PCT && !l) begin
      esc_state = ESC_PCT;
    end else begin
      push_result(b, l, 1'b0);
      esc_state = ESC_IDLE;
    end
  endfunction

  function automatic void fail_string(input logic l);
    push_result(8'h00, 1'b1, 1'b1);
    esc_state = ESC_IDLE;
    dropping  = !l;
  endfunction

  function automatic void predict_item(input logic [7:0] b, input logic l);
    if (dropping) begin
      if (l) begin
        dropping = 1'b0;
      end
      esc_state = ESC_IDLE;
      return;
    end
    if (mode_strict) begin
      case (esc_state)
        ESC_PCT: begin
          if (hex_digit(b) && !l) begin
            first_digit = b;
            esc_state   = ESC_DIGIT;
          end else begin
            fail_string(l);
          end
        end
        ESC_DIGIT: begin
          if (hex_digit(b)) begin
            push_result({nibble(first_digit), nibble(b)}, l, 1'b0);
            esc_state = ESC_IDLE;
          end else begin
            fail_string(l);
          end
        end
        default: begin
          if (b == CHAR_PCT) begin
            if (l) begin
              fail_string(l);
            end else begin
              esc_state = ESC_PCT;
            end
          end else if (allow_mask[b[7:6]][b[5:0]]) begin
            push_result(b, l, 1'b0);
            esc_state = ESC_IDLE;
          end else begin
            fail_string(l);
          end
        end
      endcase
      return;
    end
    case (esc_state)
      ESC_PCT: begin
        if (hex_digit(b)) begin
          if (l) begin
            push_result(CHAR_PCT, 1'b0, 1'b0);
            push_result(b, 1'b1, 1'b0);
            esc_state = ESC_IDLE;
          end else begin
            first_digit = b;
            esc_state   = ESC_DIGIT;
          end
        end else begin
          push_result(CHAR_PCT, 1'b0, 1'b0);
          decode_plain(b, l);
        end
      end
      ESC_DIGIT: begin
        if (hex_digit(b)) begin
          push_result({nibble(first_digit), nibble(b)}, l, 1'b0);
          esc_state = ESC_IDLE;
        end else begin
          push_result(CHAR_PCT, 1'b0, 1'b0);
          push_result(first_digit, 1'b0, 1'b0);
          decode_plain(b, l);
        end
      end
      default: begin
        decode_plain(b, l);
      end
    endcase
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_STRICT: mode_strict   = data[0];
      REG_ALLOW0: allow_mask[0] = data;
      REG_ALLOW1: allow_mask[1] = data;
      REG_ALLOW2: allow_mask[2] = data;
      REG_ALLOW3: allow_mask[3] = data;
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(15);
    if (d < 10) begin
      return 8'(CHAR_0 + d);
    end else if ($urandom_range(1) != 0) begin
      return 8'(CHAR_UA + d - 10);
    end
    return 8'(CHAR_LA + d - 10);
  endfunction

  function automatic logic [7:0] pick_literal();
    logic [7:0] c;
    c = 8'h00;
    for (int t = 0; t < 8; t++) begin
      c = 8'($urandom_range(255));
      if (c != CHAR_PCT && (!mode_strict || allow_mask[c[7:6]][c[5:0]])) begin
        return c;
      end
    end
    return c;
  endfunction

  // Each string is a run of tokens; a trailing escape fragment ends it.
  function automatic void build_string();
    int tokens;
    int r;
    tokens = $urandom_range(1, 6);
    pending_str.delete();
    for (int k = 0; k < tokens; k++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        pending_str.push_back(pick_literal());
      end else if (r < 83) begin
        pending_str.push_back(CHAR_PCT);
        pending_str.push_back(hex_char());
        pending_str.push_back(hex_char());
      end else if (r < 91) begin
        pending_str.push_back(CHAR_PCT);
        if ($urandom_range(1) != 0) begin
          pending_str.push_back(hex_char());
        end
        pending_str.push_back(8'($urandom_range(255)));
      end else if (r < 95) begin
        pending_str.push_back(CHAR_PCT);
        if ($urandom_range(1) != 0) begin
          pending_str.push_back(hex_char());
        end
        break;
      end else begin
        pending_str.push_back(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    @(negedge clk_i);
    while ($urandom_range(99) < valid_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= l;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    predict_item(b, l);
    bytes_sent++;
  endtask

  task automatic send_pending(input logic close);
    for (int i = 0; i < pending_str.size(); i++) begin
      send_byte(pending_str[i], close && (i == pending_str.size() - 1));
    end
  endtask

  task automatic send_text(input string s, input logic close);
    pending_str.delete();
    for (int i = 0; i < s.len(); i++) begin
      pending_str.push_back(s[i]);
    end
    send_pending(close);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_permissive_escapes();
    write_reg(REG_STRICT, 64'hFFFF_FFFF_FFFF_FFFE);
    send_text("%fF", 1'b1);
    send_text("%4z%%", 1'b1);
    send_text("%4", 1'b1);
    send_text("%", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_strict_errors();
    write_reg(REG_STRICT, '1);
    send_text("A-~", 1'b1);
    // The space fails the string; the rest is dropped even after a mode change.
    send_text("%41 ", 1'b0);
    wait_idle();
    write_reg(REG_STRICT, 64'hFFFF_FFFF_FFFF_FFFE);
    send_text("b", 1'b1);
    send_text("%4", 1'b0);
    wait_idle();
    write_reg(REG_STRICT, '1);
    send_text("z", 1'b1);
    send_text("%", 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("~", 1'b1);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_STRICT, 64'd1);
    for (int r = REG_ALLOW0; r <= REG_ALLOW3; r++) begin
      write_reg(CFG_IDX_W'(r), '0);
    end
    repeat (4) begin
      build_string();
      send_pending(1'b1);
    end
    wait_idle();
    for (int r = REG_ALLOW0; r <= REG_ALLOW3; r++) begin
      write_reg(CFG_IDX_W'(r), '1);
    end
    repeat (4) begin
      build_string();
      send_pending(1'b1);
    end
    wait_idle();
    // Writes to the unused indexes must leave the allowed set alone.
    for (int r = REG_ALLOW3 + 1; r < (1 << CFG_IDX_W); r++) begin
      write_reg(CFG_IDX_W'(r), {$urandom, $urandom});
    end
    repeat (4) begin
      build_string();
      send_pending(1'b1);
    end
    wait_idle();
    write_reg(REG_ALLOW0, ALLOW0_RST);
    write_reg(REG_ALLOW1, ALLOW1_RST);
    write_reg(REG_ALLOW2, ALLOW2_RST);
    write_reg(REG_ALLOW3, ALLOW3_RST);
  endtask

  task automatic test_random_strings(input int n, input logic strict_on, input logic scramble);
    int start;
    start = bytes_sent;
    write_reg(REG_STRICT, {63'd0, strict_on});
    if (scramble) begin
      for (int r = REG_ALLOW0; r <= REG_ALLOW3; r++) begin
        write_reg(CFG_IDX_W'(r), {$urandom, $urandom} | {$urandom, $urandom});
      end
    end
    while (bytes_sent - start < n) begin
      build_string();
      send_pending(1'b1);
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_reg(REG_STRICT, '0);
    @(posedge clk_i);
    hold_request = 120;
    send_text("%4z%4z%4z%4zab%41", 1'b1);
    wait_idle();
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    dec_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected item: out_byte %02h out_last %0b decode_error %0b",
               out_byte_o, out_last_o, decode_error_o);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, out_byte_o);
          mismatch_count++;
        end
        if (out_last_o !== want.last) begin
          $error("out_last: expected %0b, actual %0b", want.last, out_last_o);
          mismatch_count++;
        end
        if (decode_error_o !== want.err) begin
          $error("decode_error: expected %0b, actual %0b", want.err, decode_error_o);
          mismatch_count++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("percent_decoder: mismatch");
        $finish;
      end
    end
  end

  initial begin
    mode_strict   = 1'b0;
    allow_mask[0] = ALLOW0_RST;
    allow_mask[1] = ALLOW1_RST;
    allow_mask[2] = ALLOW2_RST;
    allow_mask[3] = ALLOW3_RST;
    esc_state     = ESC_IDLE;
    first_digit   = 8'h00;
    dropping      = 1'b0;
    valid_gap_pct   = 20;
    ready_stall_pct = 76;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_permissive_escapes();
    test_strict_errors();
    test_random_strings(100, 1'b0, 1'b0);

    valid_gap_pct   = 76;
    ready_stall_pct = 20;
    test_register_extremes();
    test_random_strings(100, 1'b1, 1'b0);

    valid_gap_pct   = 0;
    ready_stall_pct = 0;
    test_random_strings(90, 1'b1, 1'b1);
    test_backpressure();

    if (mismatch_count == 0) begin
      $display("percent_decoder: match");
    end else begin
      $display("percent_decoder: mismatch");
    end
    $finish;
  end

endmodule

@@ percent_decoder.f @@
+incdir+src
src/pdec_pkg.sv
src/pdec_front.sv
src/pdec_fifo.sv
src/pdec_back.sv
src/percent_decoder.sv
tb/testbench.sv
